// File: design/apc_pkg.sv
// ----------------------------------------------------------------------------
// apc_pkg: shared types and constants for the alpha premultiply converter
// Holds the per-lane divider state, the item carried along the cell chain,
// and the latency used by the checker and the bench.
// ----------------------------------------------------------------------------
package apc_pkg;

  localparam int CH_W      = 8;
  localparam int NUM_LANES = 3;
  localparam int DIV_STEPS = CH_W;
  localparam int LATENCY   = DIV_STEPS + 2;

  localparam logic FMT_ARGB8888 = 1'b0;
  localparam logic FMT_A8       = 1'b1;

  localparam logic REQ_PACK   = 1'b0;
  localparam logic REQ_UNPACK = 1'b1;

  localparam logic [CH_W-1:0] CH_MAX = '1;

  // How a color lane forms its final value
  typedef enum logic [1:0] {
    SEL_DIV  = 2'd0,
    SEL_RAW  = 2'd1,
    SEL_SAT  = 2'd2,
    SEL_ZERO = 2'd3
  } lane_sel_t;

  typedef struct packed {
    logic [CH_W:0]   rem;
    logic [CH_W-1:0] quo;
    logic [CH_W-1:0] raw;
    lane_sel_t       sel;
  } lane_t;

  typedef struct packed {
    logic [CH_W-1:0]                divisor;
    lane_t [NUM_LANES-1:0]          lanes;
    logic [4*CH_W-1:0]              color_out;
    logic [CH_W-1:0]                alpha_out;
  } item_t;

endpackage

// File: design/apc_prep.sv
// ----------------------------------------------------------------------------
// apc_prep: input stage
// Premultiplies ARGB8888 packs, sets up dividend and lane select for ARGB8888
// unpacks, passes A8 alpha through, and registers it into the cell chain.
// ----------------------------------------------------------------------------
module apc_prep (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic                       pixel_format,
  input  logic                       req_type,
  input  logic [4*apc_pkg::CH_W-1:0] color_in,
  input  logic [apc_pkg::CH_W-1:0]   alpha_in,
  input  logic [apc_pkg::CH_W-1:0]   red_in,
  input  logic [apc_pkg::CH_W-1:0]   green_in,
  input  logic [apc_pkg::CH_W-1:0]   blue_in,
  output logic                       vld_o,
  output apc_pkg::item_t             item_o
);
  import apc_pkg::*;

  logic                  vld_r;
  item_t                 item_r;
  item_t                 item_nxt;
  logic [CH_W-1:0]       pk_c   [NUM_LANES];
  logic [CH_W-1:0]       pk_p   [NUM_LANES];
  logic [2*CH_W:0]       pk_mul [NUM_LANES];
  logic [CH_W-1:0]       up_a;
  logic [CH_W-1:0]       up_c   [NUM_LANES];
  logic [2*CH_W-1:0]     up_div [NUM_LANES];
  logic                  up_pass;

  assign pk_c[0] = blue_in;
  assign pk_c[1] = green_in;
  assign pk_c[2] = red_in;

  assign up_a    = color_in[4*CH_W-1 -: CH_W];
  assign up_pass = (up_a == '0) || (up_a == CH_MAX);

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      pk_mul[i] = {{(CH_W+1){1'b0}}, pk_c[i]} * {{CH_W{1'b0}}, {1'b0, alpha_in} + 9'd1};
      pk_p[i]   = pk_mul[i][2*CH_W-1 -: CH_W];
      up_c[i]   = color_in[i*CH_W +: CH_W];
      // c * 255 as (c << 8) - c
      up_div[i] = {up_c[i], {CH_W{1'b0}}} - {{CH_W{1'b0}}, up_c[i]};
    end
  end

  always_comb begin
    item_nxt           = '0;
    item_nxt.divisor   = up_a;
    for (int i = 0; i < NUM_LANES; i++) begin
      item_nxt.lanes[i].raw = up_c[i];
      item_nxt.lanes[i].sel = SEL_ZERO;
    end
    if (req_type == REQ_PACK) begin
      if (pixel_format == FMT_ARGB8888) begin
        item_nxt.color_out = {alpha_in, pk_p[2], pk_p[1], pk_p[0]};
      end else begin
        item_nxt.color_out = {{(3*CH_W){1'b0}}, alpha_in};
      end
    end else if (pixel_format == FMT_ARGB8888) begin
      item_nxt.alpha_out = up_a;
      for (int i = 0; i < NUM_LANES; i++) begin
        if (up_pass) begin
          item_nxt.lanes[i].sel = SEL_RAW;
        end else if (up_c[i] >= up_a) begin
          item_nxt.lanes[i].sel = SEL_SAT;
        end else begin
          // high byte is below the divisor, so the quotient fits a byte
          item_nxt.lanes[i].sel = SEL_DIV;
          item_nxt.lanes[i].rem = {1'b0, up_div[i][2*CH_W-1 -: CH_W]};
          item_nxt.lanes[i].quo = up_div[i][CH_W-1:0];
        end
      end
    end else begin
      item_nxt.alpha_out = color_in[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign vld_o  = vld_r;
  assign item_o = item_r;

endmodule

// File: design/apc_div_cell.sv
// ----------------------------------------------------------------------------
// apc_div_cell: one restoring division step
// Produces one quotient bit for each color lane and hands the item on.
// ----------------------------------------------------------------------------
module apc_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_i,
  input  apc_pkg::item_t item_i,
  output logic           vld_o,
  output apc_pkg::item_t item_o
);
  import apc_pkg::*;

  logic            vld_r;
  item_t           item_r;
  item_t           item_nxt;
  logic [CH_W:0]   rem_sh [NUM_LANES];

  always_comb begin
    item_nxt = item_i;
    for (int i = 0; i < NUM_LANES; i++) begin
      rem_sh[i] = {item_i.lanes[i].rem[CH_W-1:0], item_i.lanes[i].quo[CH_W-1]};
      if (rem_sh[i] >= {1'b0, item_i.divisor}) begin
        item_nxt.lanes[i].rem = rem_sh[i] - {1'b0, item_i.divisor};
        item_nxt.lanes[i].quo = {item_i.lanes[i].quo[CH_W-2:0], 1'b1};
      end else begin
        item_nxt.lanes[i].rem = rem_sh[i];
        item_nxt.lanes[i].quo = {item_i.lanes[i].quo[CH_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign vld_o  = vld_r;
  assign item_o = item_r;

endmodule

// File: design/alpha_premultiply_convert_unit.sv
// ----------------------------------------------------------------------------
// alpha_premultiply_convert_unit: ARGB8888 premultiply / unpremultiply
// Takes one pixel per clock: busy is set in reset and is cleared by the first
// clock that sees reset released, and every request gives its result on
// out_strobe after one input stage, eight division cells and one output
// register. The result is shown for one cycle only, since the receiver
// cannot stall. The divide for unpacking runs as a chain of eight one-bit
// cells, so the latency is set by the quotient width. pixel_format is
// sampled as a request enters; change it only when no request is in flight.
// ----------------------------------------------------------------------------
module alpha_premultiply_convert_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_req_type,
  input  logic [4*apc_pkg::CH_W-1:0] in_color_in,
  input  logic [apc_pkg::CH_W-1:0]   in_alpha_in,
  input  logic [apc_pkg::CH_W-1:0]   in_red_in,
  input  logic [apc_pkg::CH_W-1:0]   in_green_in,
  input  logic [apc_pkg::CH_W-1:0]   in_blue_in,
  output logic                       out_strobe,
  output logic [4*apc_pkg::CH_W-1:0] out_color_out,
  output logic [apc_pkg::CH_W-1:0]   out_alpha_out,
  output logic [apc_pkg::CH_W-1:0]   out_red_out,
  output logic [apc_pkg::CH_W-1:0]   out_green_out,
  output logic [apc_pkg::CH_W-1:0]   out_blue_out,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_pixel_format
);
  import apc_pkg::*;

  logic            busy_r;
  logic            fmt_r;
  logic            accept;
  logic            stage_vld  [DIV_STEPS+1];
  item_t           stage_item [DIV_STEPS+1];
  logic            strobe_r;
  logic [4*CH_W-1:0] color_r;
  logic [CH_W-1:0] alpha_r;
  logic [CH_W-1:0] chan_r   [NUM_LANES];
  logic [CH_W-1:0] chan_nxt [NUM_LANES];
  item_t           last;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  // hold off transfers until the cycle after reset is released
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      fmt_r  <= FMT_ARGB8888;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        fmt_r <= cfg_pixel_format;
      end
    end
  end

  apc_prep u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .pixel_format (fmt_r),
    .req_type     (in_req_type),
    .color_in     (in_color_in),
    .alpha_in     (in_alpha_in),
    .red_in       (in_red_in),
    .green_in     (in_green_in),
    .blue_in      (in_blue_in),
    .vld_o        (stage_vld[0]),
    .item_o       (stage_item[0])
  );

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_cell
    apc_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (stage_vld[s]),
      .item_i (stage_item[s]),
      .vld_o  (stage_vld[s+1]),
      .item_o (stage_item[s+1])
    );
  end

  assign last = stage_item[DIV_STEPS];

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      case (last.lanes[i].sel)
        SEL_DIV:  chan_nxt[i] = last.lanes[i].quo;
        SEL_RAW:  chan_nxt[i] = last.lanes[i].raw;
        SEL_SAT:  chan_nxt[i] = CH_MAX;
        SEL_ZERO: chan_nxt[i] = '0;
        default:  chan_nxt[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= stage_vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    color_r <= last.color_out;
    alpha_r <= last.alpha_out;
    chan_r  <= chan_nxt;
  end

  assign out_strobe    = strobe_r;
  assign out_color_out = color_r;
  assign out_alpha_out = alpha_r;
  assign out_red_out   = chan_r[2];
  assign out_green_out = chan_r[1];
  assign out_blue_out  = chan_r[0];

endmodule

// File: design/apc_checker.sv
// ----------------------------------------------------------------------------
// apc_checker: port-level checks for the converter
// Ties each result strobe to the transfer a fixed latency earlier and checks
// that the fields not used by a request come out zero.
// ----------------------------------------------------------------------------
module apc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       in_req_type,
  input logic                       out_strobe,
  input logic [4*apc_pkg::CH_W-1:0] out_color_out,
  input logic [apc_pkg::CH_W-1:0]   out_alpha_out,
  input logic [apc_pkg::CH_W-1:0]   out_red_out,
  input logic [apc_pkg::CH_W-1:0]   out_green_out,
  input logic [apc_pkg::CH_W-1:0]   out_blue_out
);
  import apc_pkg::*;

  logic xfer;
  assign xfer = start && !busy;

  a_xfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    xfer |-> ##LATENCY out_strobe)
    else $error("transfer produced no result");

  a_result_has_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(xfer, LATENCY))
    else $error("result without a transfer");

  a_pack_zero_parts: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && $past(xfer && (in_req_type == REQ_PACK), LATENCY) |->
      out_alpha_out == '0 && out_red_out == '0 && out_green_out == '0 &&
      out_blue_out == '0)
    else $error("pack result with nonzero components");

  a_unpack_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && $past(xfer && (in_req_type == REQ_UNPACK), LATENCY) |->
      out_color_out == '0)
    else $error("unpack result with nonzero word");

endmodule

bind alpha_premultiply_convert_unit apc_checker u_apc_checker (.*);

// File: bench/alpha_premultiply_convert_unit_tb.sv
// ----------------------------------------------------------------------------
// alpha_premultiply_convert_unit_tb: self-checking bench for the ARGB converter
// Sends pack and unpack requests in both pixel formats, with directed corner
// pixels first and then random phases with random sender gaps. A scoreboard
// predicts every result and checks each strobed output in order.
// ----------------------------------------------------------------------------
module alpha_premultiply_convert_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import apc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_PIXELS   = 130;

  typedef struct {
    logic [31:0] color;
    logic [7:0]  alpha;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } pixel_result_t;

  class pixel_scoreboard;
    logic            pixel_format = FMT_ARGB8888;
    pixel_result_t   pending[$];
    int              mismatches = 0;
    int              unexpected = 0;
    int              checked = 0;
    int              packs = 0;
    int              unpacks = 0;
    int              a8_items = 0;
    int              saturated = 0;
    int              passthrough = 0;

    function automatic logic [7:0] premultiply(logic [7:0] c, logic [7:0] a);
      logic [15:0] prod;
      prod = {8'd0, c} * ({8'd0, a} + 16'd1);
      return prod[15:8];
    endfunction

    function automatic logic [7:0] unpremultiply(logic [7:0] c, logic [7:0] a);
      logic [15:0] quot;
      if (a == 8'd0 || a == CH_MAX) begin
        return c;
      end
      quot = ({8'd0, c} * 16'd255) / {8'd0, a};
      if (quot > 16'd255) begin
        saturated++;
        return CH_MAX;
      end
      return quot[7:0];
    endfunction

    function void note_request(logic req, logic [31:0] color, logic [7:0] a,
                               logic [7:0] r, logic [7:0] g, logic [7:0] b);
      pixel_result_t want;
      logic [7:0]    pa;
      want = '{32'd0, 8'd0, 8'd0, 8'd0, 8'd0};
      if (pixel_format == FMT_A8) a8_items++;
      if (req == REQ_PACK) begin
        packs++;
        if (pixel_format == FMT_ARGB8888) begin
          want.color = {a, premultiply(r, a), premultiply(g, a), premultiply(b, a)};
        end else begin
          want.color = {24'd0, a};
        end
      end else begin
        unpacks++;
        if (pixel_format == FMT_ARGB8888) begin
          pa = color[31:24];
          if (pa == 8'd0 || pa == CH_MAX) passthrough++;
          want.alpha = pa;
          want.red   = unpremultiply(color[23:16], pa);
          want.green = unpremultiply(color[15:8], pa);
          want.blue  = unpremultiply(color[7:0], pa);
        end else begin
          want.alpha = color[7:0];
        end
      end
      pending.push_back(want);
    endfunction

    function void check_result(pixel_result_t got);
      pixel_result_t want;
      if (pending.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display({"[%0t] result with nothing pending: ",
                    "color %08h a %02h r %02h g %02h b %02h"},
                   $realtime, got.color, got.alpha, got.red, got.green, got.blue);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.color != want.color || got.alpha != want.alpha || got.red != want.red ||
          got.green != want.green || got.blue != want.blue) begin
        mismatches++;
        if (mismatches + unexpected <= 10)
          $display({"[%0t] mismatch: want color %08h a %02h r %02h g %02h b %02h, ",
                    "got color %08h a %02h r %02h g %02h b %02h"},
                   $realtime, want.color, want.alpha, want.red, want.green, want.blue,
                   got.color, got.alpha, got.red, got.green, got.blue);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_req_type;
  logic [31:0] in_color_in;
  logic [7:0]  in_alpha_in;
  logic [7:0]  in_red_in;
  logic [7:0]  in_green_in;
  logic [7:0]  in_blue_in;
  logic        out_strobe;
  logic [31:0] out_color_out;
  logic [7:0]  out_alpha_out;
  logic [7:0]  out_red_out;
  logic [7:0]  out_green_out;
  logic [7:0]  out_blue_out;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_pixel_format;

  pixel_scoreboard sb = new();
  int              idle_cycles = 0;

  alpha_premultiply_convert_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_color_in      (in_color_in),
    .in_alpha_in      (in_alpha_in),
    .in_red_in        (in_red_in),
    .in_green_in      (in_green_in),
    .in_blue_in       (in_blue_in),
    .out_strobe       (out_strobe),
    .out_color_out    (out_color_out),
    .out_alpha_out    (out_alpha_out),
    .out_red_out      (out_red_out),
    .out_green_out    (out_green_out),
    .out_blue_out     (out_blue_out),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_pixel_format (cfg_pixel_format)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample every transfer with the values held before the edge
  always @(posedge clk) begin
    pixel_result_t got;
    if (rst_n) begin
      if (start && !busy)
        sb.note_request(in_req_type, in_color_in, in_alpha_in, in_red_in,
                        in_green_in, in_blue_in);
      if (out_strobe) begin
        got = '{out_color_out, out_alpha_out, out_red_out, out_green_out, out_blue_out};
        sb.check_result(got);
      end
      if (cfg_valid && cfg_ready) sb.pixel_format = cfg_pixel_format;
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog expired with %0d results pending", $realtime,
               sb.pending.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Leaves start high; the caller lowers it when a gap follows
  task automatic send_pixel(input logic req, input logic [31:0] color,
                            input logic [7:0] a, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b);
    start       <= 1'b1;
    in_req_type <= req;
    in_color_in <= color;
    in_alpha_in <= a;
    in_red_in   <= r;
    in_green_in <= g;
    in_blue_in  <= b;
    do @(posedge clk); while (busy);
  endtask

  task automatic sender_gap(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Hold off until every pending result has been checked
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_format(input logic fmt);
    cfg_valid        <= 1'b1;
    cfg_pixel_format <= fmt;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_pixel();
    logic [31:0] color;
    logic [7:0]  a;
    color = $urandom();
    a     = 8'($urandom());
    case ($urandom_range(0, 9))
      0: color[31:24] = 8'd0;
      1: color[31:24] = CH_MAX;
      2: color[31:24] = 8'($urandom_range(1, 8));
      3: color[31:24] = 8'($urandom_range(247, 254));
      4: a = 8'd0;
      5: a = CH_MAX;
      default: ;
    endcase
    send_pixel(1'($urandom_range(0, 1)), color, a, 8'($urandom()), 8'($urandom()),
               8'($urandom()));
  endtask

  initial begin
    logic fmt;
    start            = 1'b0;
    rst_n            = 1'b0;
    in_req_type      = REQ_PACK;
    in_color_in      = '0;
    in_alpha_in      = '0;
    in_red_in        = '0;
    in_green_in      = '0;
    in_blue_in       = '0;
    cfg_valid        = 1'b0;
    cfg_pixel_format = FMT_ARGB8888;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_format(FMT_ARGB8888);
    // premultiply corners: zero alpha, full alpha, half and minimal alpha
    send_pixel(REQ_PACK, 32'hA5A5A5A5, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(REQ_PACK, 32'h5A5A5A5A, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(REQ_PACK, 32'hFFFFFFFF, 8'hFF, 8'h00, 8'h80, 8'h01);
    send_pixel(REQ_PACK, 32'h00000000, 8'h80, 8'hFF, 8'h7F, 8'h01);
    send_pixel(REQ_PACK, 32'h12345678, 8'h01, 8'hFF, 8'hFE, 8'h00);
    // unpremultiply: pass-through alphas, saturation, exact boundaries
    send_pixel(REQ_UNPACK, 32'h00123456, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(REQ_UNPACK, 32'hFF123456, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(REQ_UNPACK, 32'h01FF0100, 8'h11, 8'h22, 8'h33, 8'h44);
    send_pixel(REQ_UNPACK, 32'h807F80FF, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(REQ_UNPACK, 32'hFEFEFD00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(REQ_UNPACK, 32'hFFFFFFFF, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(REQ_UNPACK, 32'h00000000, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(REQ_UNPACK, 32'h4040413F, 8'h00, 8'h00, 8'h00, 8'h00);
    drain();

    write_format(FMT_A8);
    send_pixel(REQ_PACK, 32'hFFFFFFFF, 8'hFF, 8'h12, 8'h34, 8'h56);
    send_pixel(REQ_PACK, 32'hFFFFFFFF, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(REQ_UNPACK, 32'hFFFFFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(REQ_UNPACK, 32'h123456A5, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(REQ_UNPACK, 32'h00000000, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      fmt = (phase % 2 == 0) ? FMT_ARGB8888 : FMT_A8;
      write_format(fmt);
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        send_random_pixel();
        if (i == 65) begin
          drain();
        end else if (i < 40 || i >= 80) begin
          // random gaps outside the back-to-back stretch in the middle of each phase
          sender_gap(pick_gap());
        end
      end
      drain();
    end

    repeat (LATENCY + 4) @(posedge clk);
    $display("Sent %0d packs and %0d unpacks (%0d in A8 format); %0d results checked",
             sb.packs, sb.unpacks, sb.a8_items, sb.checked);
    $display("Unpack corners hit: %0d saturated channels, %0d pass-through alphas",
             sb.saturated, sb.passthrough);
    if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d unexpected results, %0d results missing",
               sb.mismatches, sb.unexpected, sb.pending.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
